FILE: src/sandpile_slope_relaxation_top_assert.svh
// ----------------------------------------------------------------------------
// Sandpile slope relaxation assertion macros
// Shared concurrent assertion forms for the sandpile slope relaxation block.
// ----------------------------------------------------------------------------
`ifndef SANDPILE_SLOPE_RELAXATION_TOP_ASSERT_SVH
`define SANDPILE_SLOPE_RELAXATION_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// Sandpile slope relaxation package
// Field widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int MAX_COLUMNS_DEF = 32;
    localparam int SLOPE_BITS_DEF  = 8;

    localparam int POS_W    = 5;
    localparam int ADD_W    = 4;
    localparam int COLIDX_W = 5;
    localparam int HEIGHT_W = 9;
    localparam int THR_W    = 4;
    localparam int COLS_W   = 6;
    localparam int CNT_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 9'd511;
    localparam logic [THR_W-1:0]    THR_RESET  = 4'd2;
    localparam logic [COLS_W-1:0]   COLS_RESET = 6'd20;

    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE  = 8'd1;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [CNT_W-1:0] columns;
    } cfg_t;

endpackage

FILE: src/sps_core.sv
// ----------------------------------------------------------------------------
// Sandpile slope relaxation core
// Slope memory with a read-modify-write sequencer for adding, sweeping and
// streaming the column heights.
// ----------------------------------------------------------------------------
module sps_core #(
    parameter int MAX_COLUMNS = sps_pkg::MAX_COLUMNS_DEF,
    parameter int SLOPE_BITS  = sps_pkg::SLOPE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sps_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sps_pkg::POS_W-1:0]     in_position,
    input  logic [sps_pkg::ADD_W-1:0]     in_add_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sps_pkg::COLIDX_W-1:0]  out_column_index,
    output logic [sps_pkg::HEIGHT_W-1:0]  out_height,
    output logic                          out_last
);

    localparam int IDX_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = sps_pkg::CNT_W;
    localparam int RAW_SW = SLOPE_BITS + IDX_W + 1;
    localparam int SUM_W  = (RAW_SW > sps_pkg::HEIGHT_W + 1) ? RAW_SW : sps_pkg::HEIGHT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CHK_RD,
        S_CHK,
        S_TGT_RD,
        S_TGT,
        S_LEFT_RD,
        S_LEFT,
        S_OUT_RD,
        S_OUT
    } state_t;

    function automatic logic [SLOPE_BITS-1:0] sat_add(
        input logic [SLOPE_BITS-1:0]         a,
        input logic [sps_pkg::THR_W-1:0]     b
    );
        logic [SLOPE_BITS:0] s;
        s = {1'b0, a} + (SLOPE_BITS + 1)'(b);
        sat_add = s[SLOPE_BITS] ? {SLOPE_BITS{1'b1}} : s[SLOPE_BITS-1:0];
    endfunction

    logic [SLOPE_BITS-1:0] mem [MAX_COLUMNS];
    logic [SLOPE_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic [MAX_COLUMNS-1:0] vld_reg;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              tgt_reg, tgt_next;
    logic                          moved_reg, moved_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [SUM_W-1:0]              rem_reg, rem_next;
    logic [sps_pkg::ADD_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sps_pkg::COLIDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [sps_pkg::HEIGHT_W-1:0]  out_height_reg, out_height_next;
    logic                          out_last_reg, out_last_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SLOPE_BITS-1:0] wr_data;

    logic [SLOPE_BITS-1:0]     cur;
    logic [CNT_W-1:0]          n_last;
    logic [CNT_W-1:0]          idx_ext;
    logic [CNT_W-1:0]          pos_ext;
    logic                      at_last;
    logic                      pos_ok;
    logic [CNT_W:0]            tgt_sum;
    logic [CNT_W:0]            tgt_sel;
    logic [SLOPE_BITS-1:0]     p_ext;
    logic [sps_pkg::THR_W:0]   p_plus;
    logic                      topples;
    logic                      accept;
    logic                      out_free;
    logic                      adv;

    assign cur     = rd_vld_reg ? rd_data_reg : '0;
    assign n_last  = cfg.columns - CNT_W'(1);
    assign idx_ext = CNT_W'(idx_reg);
    assign pos_ext = CNT_W'(in_position);
    assign at_last = (idx_ext == n_last);
    assign pos_ok  = (pos_ext < cfg.columns);
    assign tgt_sum = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(cfg.threshold);
    assign tgt_sel = (tgt_sum > {1'b0, n_last}) ? {1'b0, n_last} : tgt_sum;
    assign p_ext   = SLOPE_BITS'(cfg.threshold);
    assign p_plus  = {1'b0, cfg.threshold} + (sps_pkg::THR_W + 1)'(1);
    assign topples = (cur > p_ext);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        tgt_next        = tgt_reg;
        moved_next      = moved_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_idx_next    = out_idx_reg;
        out_height_next = out_height_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = cur;
        adv             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = in_add_count;
                    pos_next   = pos_ext[IDX_W-1:0];
                    idx_next   = '0;
                    moved_next = 1'b0;
                    sum_next   = '0;
                    if (pos_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_ext[IDX_W-1:0];
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_CHK_RD;
                    end
                end
            end
            S_ADD:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = sat_add(cur, cnt_reg);
                state_next = S_CHK_RD;
            end
            S_CHK_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (topples)
                begin
                    wr_en      = 1'b1;
                    wr_data    = cur - SLOPE_BITS'(p_plus);
                    moved_next = 1'b1;
                    tgt_next   = tgt_sel[IDX_W-1:0];
                    state_next = S_TGT_RD;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(cur);
                    adv      = 1'b1;
                end
            end
            S_TGT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = tgt_reg;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                wr_en   = 1'b1;
                wr_addr = tgt_reg;
                wr_data = sat_add(cur, sps_pkg::THR_W'(1));
                if (idx_reg != '0)
                begin
                    state_next = S_LEFT_RD;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_LEFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg - IDX_W'(1);
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - IDX_W'(1);
                wr_data = sat_add(cur, cfg.threshold);
                adv     = 1'b1;
            end
            S_OUT_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = idx_ext[sps_pkg::COLIDX_W-1:0];
                    out_height_next = (rem_reg > SUM_W'(sps_pkg::HEIGHT_MAX)) ?
                                      sps_pkg::HEIGHT_MAX : rem_reg[sps_pkg::HEIGHT_W-1:0];
                    out_last_next   = at_last;
                    rem_next        = rem_reg - SUM_W'(cur);
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (!at_last)
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_CHK_RD;
            end
            else if (moved_next)
            begin
                idx_next   = '0;
                moved_next = 1'b0;
                sum_next   = '0;
                state_next = S_CHK_RD;
            end
            else
            begin
                idx_next   = '0;
                rem_next   = sum_next;
                state_next = S_OUT_RD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            tgt_reg        <= '0;
            moved_reg      <= 1'b0;
            sum_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_idx_reg    <= '0;
            out_height_reg <= '0;
            out_last_reg   <= 1'b0;
            vld_reg        <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            tgt_reg        <= tgt_next;
            moved_reg      <= moved_next;
            sum_reg        <= sum_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            out_idx_reg    <= out_idx_next;
            out_height_reg <= out_height_next;
            out_last_reg   <= out_last_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_column_index = out_idx_reg;
    assign out_height       = out_height_reg;
    assign out_last         = out_last_reg;

endmodule

FILE: src/sandpile_slope_relaxation_top.sv
// ----------------------------------------------------------------------------
// Sandpile slope relaxation top level
// One-dimensional sandpile held as slopes: add grains, relax, stream heights.
// ----------------------------------------------------------------------------
// Usage: a transaction on the s_axis channel carries a position and a grain
// count. The block adds the grains, relaxes the pile with full sweeps until a
// sweep topples nothing, and then sends one m_axis transaction per active
// column, column 0 first, with tlast on the final column. Configuration
// writes on the cfg channel set the threshold (index 0) and the column count
// (index 1); cfg_ready is always high, and writes belong to idle periods.
// Operation: every access goes through the single read port of the slope memory.
// The add step is skipped when the position lies outside the pile. A sweep
// reads and checks each column in turn; a toppling column also updates its
// target and, except at column 0, its left neighbour. After the last sweep,
// each result needs its own column read. Only one item is in work at a time;
// the next is accepted once the last result is in the output register. When
// the receiver stalls, the stream holds with the current result in the output
// register. Reset empties the pile at once through per-entry valid flags,
// restores the register defaults and drops output.
// ----------------------------------------------------------------------------
`include "sandpile_slope_relaxation_top_assert.svh"

module sandpile_slope_relaxation_top #(
    parameter int MAX_COLUMNS = sps_pkg::MAX_COLUMNS_DEF,
    parameter int SLOPE_BITS  = sps_pkg::SLOPE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position [4:0], add_count [8:5], zeros above.
    input  logic [sps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // column_index [4:0], height [13:5], zeros above.
    output logic [sps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int CNT_W = sps_pkg::CNT_W;

    logic [sps_pkg::THR_W-1:0]    thr_reg;
    logic [sps_pkg::COLS_W-1:0]   cols_reg;
    sps_pkg::cfg_t                cfg_eff;
    logic [CNT_W-1:0]             cols_ext;
    logic [CNT_W-1:0]             last_col;
    logic [sps_pkg::COLIDX_W-1:0] col_idx;
    logic [sps_pkg::HEIGHT_W-1:0] height;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= sps_pkg::THR_RESET;
            cols_reg <= sps_pkg::COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == sps_pkg::REG_SLOPE_THRESHOLD)
            begin
                thr_reg <= cfg_data[sps_pkg::THR_W-1:0];
            end
            else if (cfg_index == sps_pkg::REG_COLUMNS_IN_USE)
            begin
                cols_reg <= cfg_data[sps_pkg::COLS_W-1:0];
            end
        end
    end

    assign cols_ext = CNT_W'(cols_reg);

    always_comb
    begin
        cfg_eff.threshold = (thr_reg == '0) ? sps_pkg::THR_W'(1) : thr_reg;
        if (cols_ext < CNT_W'(2))
        begin
            cfg_eff.columns = CNT_W'(2);
        end
        else if (cols_ext > CNT_W'(MAX_COLUMNS))
        begin
            cfg_eff.columns = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cfg_eff.columns = cols_ext;
        end
    end

    assign last_col = cfg_eff.columns - CNT_W'(1);

    sps_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SLOPE_BITS  (SLOPE_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_eff),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_position      (s_axis_tdata[sps_pkg::POS_W-1:0]),
        .in_add_count     (s_axis_tdata[sps_pkg::POS_W +: sps_pkg::ADD_W]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_column_index (col_idx),
        .out_height       (height),
        .out_last         (m_axis_tlast)
    );

    assign m_axis_tdata = sps_pkg::OUT_DATA_W'({height, col_idx});

    `SPS_ASSERT_SAME(a_last_on_final_column, clk, rst_n,
        m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[sps_pkg::COLIDX_W-1:0] == last_col[sps_pkg::COLIDX_W-1:0],
        "tlast marks a column other than the final one")
    `SPS_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready,
        "input accepted while the previous item is still in work")

endmodule

FILE: dv/sandpile_slope_relaxation_top_tb.sv
// ----------------------------------------------------------------------------
// Sandpile slope relaxation testbench
// Sends grain additions to the block under several threshold and column
// settings and keeps a behavioral copy of the slope pile. Every streamed
// column height, index and end marker is checked in order against that copy,
// with random idle cycles on both the input and the output side.
// ----------------------------------------------------------------------------
module sandpile_slope_relaxation_top_tb;

    localparam int PILE_DEPTH   = sps_pkg::MAX_COLUMNS_DEF;
    localparam int SLOPE_CEIL   = (1 << sps_pkg::SLOPE_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 146;
    localparam int MAX_REPORTS  = 20;

    localparam logic [sps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED     = 8'd2;
    localparam logic [sps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

    typedef struct {
        logic [sps_pkg::COLIDX_W-1:0] column;
        logic [sps_pkg::HEIGHT_W-1:0] height;
        logic                         is_final;
    } column_report_t;

    typedef struct {
        bit                            is_write;
        logic [sps_pkg::CFG_IDX_W-1:0] reg_index;
        logic [sps_pkg::CFG_DATA_W-1:0] reg_value;
        logic [sps_pkg::POS_W-1:0]     position;
        logic [sps_pkg::ADD_W-1:0]     grains;
        bit                            typed;
        int                            flat_height;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [sps_pkg::IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [sps_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tlast;

    logic [sps_pkg::SLOPE_BITS_DEF-1:0] pile_slope [PILE_DEPTH];
    logic [sps_pkg::THR_W-1:0]          threshold_reg = sps_pkg::THR_RESET;
    logic [sps_pkg::COLS_W-1:0]         columns_reg = sps_pkg::COLS_RESET;

    column_report_t column_q [$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  writes_done = 0;
    int  tallest = 0;
    int  most_topples = 0;
    int  cycle_count = 0;
    int  cycle_limit = 50000;
    bit  no_idle = 1'b0;

    sandpile_slope_relaxation_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int active_columns();
        int n;
        n = int'(columns_reg);
        if (n < 2) n = 2;
        if (n > PILE_DEPTH) n = PILE_DEPTH;
        return n;
    endfunction

    function automatic logic [sps_pkg::SLOPE_BITS_DEF-1:0] grow_slope(int base, int amount);
        int sum;
        sum = base + amount;
        return sps_pkg::SLOPE_BITS_DEF'((sum > SLOPE_CEIL) ? SLOPE_CEIL : sum);
    endfunction

    function automatic stim_row_t grain_row(int pos, int cnt, bit typed, int flat);
        stim_row_t row;
        row = '{is_write: 1'b0, reg_index: '0, reg_value: '0,
                position: sps_pkg::POS_W'(pos), grains: sps_pkg::ADD_W'(cnt),
                typed: typed, flat_height: flat};
        return row;
    endfunction

    function automatic stim_row_t write_row(logic [sps_pkg::CFG_IDX_W-1:0] idx, int value);
        stim_row_t row;
        row = '{is_write: 1'b1, reg_index: idx, reg_value: sps_pkg::CFG_DATA_W'(value),
                position: '0, grains: '0, typed: 1'b0, flat_height: 0};
        return row;
    endfunction

    // Adds the grains, relaxes the shadow pile and queues one report per column.
    task automatic relax_and_measure(input logic [sps_pkg::POS_W-1:0] pos,
                                     input logic [sps_pkg::ADD_W-1:0] grains,
                                     input bit typed, input int flat, output int work);
        int n;
        int p;
        int sweeps;
        int topples;
        int target;
        int acc;
        bit moved;
        int col_height [PILE_DEPTH];
        column_report_t report;
        n = active_columns();
        p = (threshold_reg == 0) ? 1 : int'(threshold_reg);
        if (pos < n) pile_slope[pos] = grow_slope(int'(pile_slope[pos]), int'(grains));
        sweeps = 0;
        topples = 0;
        moved = 1'b1;
        while (moved)
        begin
            moved = 1'b0;
            sweeps++;
            for (int i = 0; i < n; i++)
            begin
                if (pile_slope[i] > p)
                begin
                    moved = 1'b1;
                    topples++;
                    target = (i + p > n - 1) ? n - 1 : i + p;
                    pile_slope[i] = sps_pkg::SLOPE_BITS_DEF'(int'(pile_slope[i]) - (p + 1));
                    pile_slope[target] = grow_slope(int'(pile_slope[target]), 1);
                    if (i > 0) pile_slope[i - 1] = grow_slope(int'(pile_slope[i - 1]), p);
                end
            end
        end
        acc = 0;
        for (int k = n - 1; k >= 0; k--)
        begin
            acc += int'(pile_slope[k]);
            if (acc > sps_pkg::HEIGHT_MAX) acc = int'(sps_pkg::HEIGHT_MAX);
            col_height[k] = acc;
        end
        for (int k = 0; k < n; k++)
        begin
            report.column = sps_pkg::COLIDX_W'(k);
            report.height = sps_pkg::HEIGHT_W'(typed ? flat : col_height[k]);
            report.is_final = (k == n - 1);
            column_q.push_back(report);
        end
        if (topples > most_topples) most_topples = topples;
        work = 2 + sweeps * 2 * n + 6 * topples + 8 * n;
    endtask

    task automatic send_grains(input logic [sps_pkg::POS_W-1:0] pos,
                               input logic [sps_pkg::ADD_W-1:0] grains,
                               input bit typed, input int flat);
        int gap;
        int work;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sps_pkg::IN_DATA_W - sps_pkg::ADD_W - sps_pkg::POS_W){1'b0}},
                          grains, pos};
        do @(posedge clk); while (!s_axis_tready);
        relax_and_measure(pos, grains, typed, flat, work);
        items_sent++;
        cycle_limit += 4 * (work + 10);
    endtask

    task automatic write_register(input logic [sps_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sps_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == sps_pkg::REG_SLOPE_THRESHOLD) threshold_reg = value[sps_pkg::THR_W-1:0];
        else if (idx == sps_pkg::REG_COLUMNS_IN_USE) columns_reg = value[sps_pkg::COLS_W-1:0];
        writes_done++;
    endtask

    // Sampled at the falling edge so the check never races the output monitor.
    task automatic drain_stream();
        while (column_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_stream
        column_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (m_axis_tdata[13:5] > tallest) tallest = int'(m_axis_tdata[13:5]);
            if (column_q.size() == 0)
            begin
                report_mismatch("unexpected column transaction, pending count", 0, 1);
            end
            else
            begin
                want = column_q.pop_front();
                if (m_axis_tdata[4:0] != want.column)
                    report_mismatch("column_index", int'(want.column),
                                    int'(m_axis_tdata[4:0]));
                if (m_axis_tdata[13:5] != want.height)
                    report_mismatch("height", int'(want.height), int'(m_axis_tdata[13:5]));
                if (m_axis_tlast != want.is_final)
                    report_mismatch("last", int'(want.is_final), int'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("Timeout after %0d cycles with %0d column transactions pending",
                     cycle_count, column_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : drain_side
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : source_side
        stim_row_t script [$];
        bit writing;
        int random_items;
        int burst;
        int n;
        int pick;
        logic [sps_pkg::POS_W-1:0] pos;
        logic [sps_pkg::ADD_W-1:0] grains;
        logic [3:0] thr_value;
        logic [5:0] cols_value;
        logic [3:0] thr_pad;
        logic [1:0] cols_pad;

        foreach (pile_slope[i]) pile_slope[i] = '0;

        // Reset settings: threshold 2, 20 columns.
        script.push_back(grain_row(0, 0, 1'b1, 0));
        script.push_back(grain_row(19, 2, 1'b1, 2));
        script.push_back(grain_row(20, 15, 1'b1, 2));
        script.push_back(grain_row(31, 15, 1'b1, 2));
        script.push_back(grain_row(0, 15, 1'b0, 0));
        script.push_back(grain_row(7, 9, 1'b0, 0));
        script.push_back(grain_row(19, 3, 1'b0, 0));
        // Widest pile with the steepest threshold.
        script.push_back(write_row(sps_pkg::REG_SLOPE_THRESHOLD, 15));
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 32));
        script.push_back(grain_row(31, 15, 1'b0, 0));
        script.push_back(grain_row(0, 15, 1'b0, 0));
        script.push_back(grain_row(16, 10, 1'b0, 0));
        script.push_back(grain_row(15, 5, 1'b0, 0));
        // Narrowest pile with the shallowest threshold.
        script.push_back(write_row(sps_pkg::REG_SLOPE_THRESHOLD, 1));
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 2));
        script.push_back(grain_row(0, 15, 1'b0, 0));
        script.push_back(grain_row(1, 15, 1'b0, 0));
        script.push_back(grain_row(2, 4, 1'b0, 0));
        // A zero threshold behaves as one and a zero column count as two.
        script.push_back(write_row(sps_pkg::REG_SLOPE_THRESHOLD, 8'h00));
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 8'h00));
        script.push_back(grain_row(1, 7, 1'b0, 0));
        script.push_back(grain_row(0, 10, 1'b0, 0));
        // Upper data bits are ignored and an oversized column count clamps.
        script.push_back(write_row(sps_pkg::REG_SLOPE_THRESHOLD, 8'hF3));
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 8'hFF));
        script.push_back(grain_row(30, 11, 1'b0, 0));
        script.push_back(grain_row(0, 6, 1'b0, 0));
        script.push_back(write_row(REG_UNMAPPED, 8'hFF));
        script.push_back(write_row(REG_UNMAPPED_TOP, 8'h00));
        script.push_back(grain_row(17, 15, 1'b0, 0));
        // Shrinking leaves the outer slopes parked until the pile grows again.
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 6));
        script.push_back(grain_row(5, 15, 1'b0, 0));
        script.push_back(grain_row(3, 12, 1'b0, 0));
        script.push_back(write_row(sps_pkg::REG_COLUMNS_IN_USE, 32));
        script.push_back(grain_row(31, 1, 1'b0, 0));
        script.push_back(grain_row(10, 10, 1'b0, 0));
        script.push_back(grain_row(21, 8, 1'b0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        writing = 1'b0;
        foreach (script[r])
        begin
            if (script[r].is_write)
            begin
                if (!writing)
                begin
                    s_axis_tvalid <= 1'b0;
                    drain_stream();
                end
                write_register(script[r].reg_index, script[r].reg_value);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                begin
                    cfg_valid <= 1'b0;
                    writing = 1'b0;
                end
                send_grains(script[r].position, script[r].grains, script[r].typed,
                            script[r].flat_height);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            s_axis_tvalid <= 1'b0;
            drain_stream();
            no_idle = ($urandom_range(0, 3) == 0);

            pick = $urandom_range(0, 9);
            if (pick == 0) thr_value = 4'd0;
            else if (pick == 1) thr_value = 4'd15;
            else if (pick == 2) thr_value = 4'd1;
            else thr_value = 4'($urandom_range(1, 15));
            thr_pad = 4'($urandom_range(0, 15));
            write_register(sps_pkg::REG_SLOPE_THRESHOLD, {thr_pad, thr_value});

            pick = $urandom_range(0, 9);
            if (pick == 0) cols_value = 6'($urandom_range(0, 1));
            else if (pick == 1) cols_value = 6'($urandom_range(33, 63));
            else if (pick == 2) cols_value = 6'd32;
            else if (pick == 3) cols_value = 6'd2;
            else cols_value = 6'($urandom_range(2, 32));
            cols_pad = 2'($urandom_range(0, 3));
            write_register(sps_pkg::REG_COLUMNS_IN_USE, {cols_pad, cols_value});

            if ($urandom_range(0, 4) == 0)
                write_register(sps_pkg::CFG_IDX_W'(int'(sps_pkg::REG_COLUMNS_IN_USE) + 1 +
                                                  $urandom_range(0, 253)),
                               sps_pkg::CFG_DATA_W'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;

            n = active_columns();
            burst = $urandom_range(8, 24);
            for (int k = 0; k < burst && random_items < RANDOM_ITEMS; k++)
            begin
                if (k != 0 && $urandom_range(0, 15) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    drain_stream();
                end
                if (n < PILE_DEPTH && $urandom_range(0, 7) == 0)
                    pos = sps_pkg::POS_W'($urandom_range(n, PILE_DEPTH - 1));
                else
                    pos = sps_pkg::POS_W'($urandom_range(0, n - 1));
                grains = ($urandom_range(0, 3) == 0) ? 4'd15 :
                         sps_pkg::ADD_W'($urandom_range(0, 15));
                send_grains(pos, grains, 1'b0, 0);
                random_items++;
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_stream();
        repeat (40) @(posedge clk);
        mismatch_count += column_q.size();

        $display("Run covered %0d grain transactions, %0d column transactions, %0d writes.",
                 items_sent, results_seen, writes_done);
        $display("Tallest column seen %0d, longest avalanche %0d topples.",
                 tallest, most_topples);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
